### hdl/jtl_pkg.sv
// Shared types, codes and helpers for the JSON token lexer.
package jtl_pkg;

  // Lexer mode between bytes
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_NUMBER  = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_LITERAL = 2'd3
  } mode_t;

  // Token kind codes
  localparam logic [3:0] KIND_STRING  = 4'd0;
  localparam logic [3:0] KIND_NUMBER  = 4'd1;
  localparam logic [3:0] KIND_BOOL    = 4'd2;
  localparam logic [3:0] KIND_NULL    = 4'd3;
  localparam logic [3:0] KIND_LBRACK  = 4'd4;
  localparam logic [3:0] KIND_RBRACK  = 4'd5;
  localparam logic [3:0] KIND_LBRACE  = 4'd6;
  localparam logic [3:0] KIND_RBRACE  = 4'd7;
  localparam logic [3:0] KIND_COLON   = 4'd8;
  localparam logic [3:0] KIND_COMMA   = 4'd9;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;

  // Literal words, first letter in the low byte
  localparam logic [31:0] WORD_NULL  = 32'h6C6C756E;
  localparam logic [31:0] WORD_TRUE  = 32'h65757274;
  localparam logic [39:0] WORD_FALSE = 40'h65736C6166;

  localparam int LitBytes   = 5;
  localparam int MaxResults = 3;
  localparam int QueueDepth = 4;

  // One result beat without the run marker
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] value;
    logic       has;
    logic       tend;
    logic       mal;
  } result_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [MaxResults-1:0]    res;
  } entry_t;

  function automatic result_t mk_res(logic [3:0] kind, logic [7:0] value,
                                     logic has, logic tend, logic mal);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.has   = has;
    r.tend  = tend;
    r.mal   = mal;
    return r;
  endfunction

endpackage

### hdl/jtl_ifs.sv
// Channel interfaces for the lexer: text byte input and token result output.
interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_file;

  modport source (output valid, output data_byte, output last_of_file, input ready);
  modport sink (input valid, input data_byte, input last_of_file, output ready);
endinterface

interface jtl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_class;
  logic [7:0] value_byte;
  logic       has_byte;
  logic       token_end;
  logic       malformed;
  logic       run_last;

  modport source (output valid, output token_class, output value_byte, output has_byte,
                  output token_end, output malformed, output run_last, input ready);
  modport sink (input valid, input token_class, input value_byte, input has_byte,
                input token_end, input malformed, input run_last, output ready);
endinterface

### hdl/json_token_lexer_core.sv
// Top level of the streaming JSON token lexer.
//
// Usage: text bytes enter on in_ch, one per beat, with last_of_file on the
// final byte of a text; token results leave on out_ch, one per beat.
// Each byte gives zero to three results; run_last marks the last result of
// a byte, token_end the last result of a token.
// Path: the front end lexes into the queue, the back end loads the output
// register. Throughput: one byte per cycle on the input while the queue is
// not full; the output register moves one result per cycle while the
// receiver is ready, so a byte with several results holds the output
// while the queue (QUEUE_DEPTH groups) absorbs input.
// Reset (synchronous, active low) returns the lexer to idle, empties the
// queue and drops out_ch.valid; the next byte starts a new text.
// When the receiver stalls, the output beat holds, the queue fills and
// in_ch.ready drops only once all QUEUE_DEPTH entries are taken.
// Bytes with no result are taken at one per cycle while the queue has room.
module json_token_lexer_core #(
  parameter int QUEUE_DEPTH = jtl_pkg::QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  jtl_in_if.sink    in_ch,
  jtl_out_if.source out_ch
);

  logic             q_push, q_full, q_empty, q_pop;
  jtl_pkg::entry_t  q_in, q_head;
  jtl_pkg::result_t res;
  logic             run_last;

  // Lex input beats into result groups
  jtl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.data_byte),
    .in_last    (in_ch.last_of_file),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  // Buffer groups between the two ends
  jtl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .empty      (q_empty),
    .pop        (q_pop),
    .head       (q_head)
  );

  // Serialize groups into result beats
  jtl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_res      (res),
    .out_run_last (run_last)
  );

  assign out_ch.token_class = res.kind;
  assign out_ch.value_byte  = res.value;
  assign out_ch.has_byte    = res.has;
  assign out_ch.token_end   = res.tend;
  assign out_ch.malformed   = res.mal;
  assign out_ch.run_last    = run_last;

  // Front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue overflow");

  // A beat without a text byte is always an end marker
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.has_byte) |-> out_ch.token_end)
    else $error("byteless beat not marked as token end");

  // Malformed results are only ever bools
  a_malformed_bool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.malformed) |-> (out_ch.token_class == jtl_pkg::KIND_BOOL))
    else $error("malformed flag on non-bool token");

  // Reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

### hdl/jtl_front.sv
// Front end: accepts text bytes, runs the lexer state and packs each byte's results.
module jtl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             q_full,
  output logic             push,
  output jtl_pkg::entry_t  push_entry
);

  localparam int BufW = 8 * jtl_pkg::LitBytes;

  jtl_pkg::mode_t   mode_r, mode_nxt;
  logic [BufW-1:0]  buf_r, buf_nxt;
  logic [2:0]       len_r, len_nxt;
  logic             fail_r, fail_nxt;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Hold lexer state between beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jtl_pkg::MODE_IDLE;
      buf_r  <= '0;
      len_r  <= '0;
      fail_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
      len_r  <= len_nxt;
      fail_r <= fail_nxt;
    end
  end

  // Lex one byte: next state and up to three results
  always_comb begin
    logic [7:0]                                c;
    logic [1:0]                                n;
    logic                                      go_idle;
    jtl_pkg::result_t [jtl_pkg::MaxResults-1:0] slots;
    c        = in_byte;
    n        = 2'd0;
    go_idle  = 1'b0;
    slots    = '0;
    mode_nxt = mode_r;
    buf_nxt  = buf_r;
    len_nxt  = len_r;
    fail_nxt = fail_r;

    unique case (mode_r)
      jtl_pkg::MODE_NUMBER: begin
        if ((c >= jtl_pkg::CH_ZERO && c <= jtl_pkg::CH_NINE) || c == jtl_pkg::CH_DOT) begin
          slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, c, 1'b1, 1'b0, 1'b0);
          n = n + 2'd1;
        end else begin
          // close the number, then lex the terminator afresh
          slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1, 1'b0);
          n = n + 2'd1;
          mode_nxt = jtl_pkg::MODE_IDLE;
          go_idle  = 1'b1;
        end
      end
      jtl_pkg::MODE_STRING: begin
        if (c == jtl_pkg::CH_QUOTE) begin
          slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
          n = n + 2'd1;
          mode_nxt = jtl_pkg::MODE_IDLE;
        end else begin
          slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_STRING, c, 1'b1, 1'b0, 1'b0);
          n = n + 2'd1;
        end
      end
      jtl_pkg::MODE_LITERAL: begin
        if (fail_r || len_r >= 3'(jtl_pkg::LitBytes)) begin
          fail_nxt = 1'b1;
        end else begin
          buf_nxt[{len_r, 3'b000} +: 8] = c;
          len_nxt = len_r + 3'd1;
          if (len_nxt == 3'd4 && buf_nxt[31:0] == jtl_pkg::WORD_NULL) begin
            slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NULL, buf_nxt[7:0], 1'b1, 1'b1, 1'b0);
            n = n + 2'd1;
            mode_nxt = jtl_pkg::MODE_IDLE;
            buf_nxt  = '0;
            len_nxt  = '0;
            fail_nxt = 1'b0;
          end else if ((len_nxt == 3'd4 && buf_nxt[31:0] == jtl_pkg::WORD_TRUE) ||
                       (len_nxt == 3'd5 && buf_nxt == jtl_pkg::WORD_FALSE)) begin
            slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_BOOL, buf_nxt[7:0], 1'b1, 1'b1, 1'b0);
            n = n + 2'd1;
            mode_nxt = jtl_pkg::MODE_IDLE;
            buf_nxt  = '0;
            len_nxt  = '0;
            fail_nxt = 1'b0;
          end else if (len_nxt >= 3'(jtl_pkg::LitBytes)) begin
            fail_nxt = 1'b1;
          end
        end
      end
      jtl_pkg::MODE_IDLE: begin
        go_idle = 1'b1;
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    // Idle lexing: skip whitespace, emit punctuation, start tokens, drop the rest
    if (go_idle) begin
      priority if ((c >= jtl_pkg::CH_TAB && c <= jtl_pkg::CH_CR) || c == jtl_pkg::CH_SPACE) begin
        n = n;
      end else if (c == jtl_pkg::CH_LBRACK) begin
        slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_LBRACK, c, 1'b1, 1'b1, 1'b0);
        n = n + 2'd1;
      end else if (c == jtl_pkg::CH_RBRACK) begin
        slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_RBRACK, c, 1'b1, 1'b1, 1'b0);
        n = n + 2'd1;
      end else if (c == jtl_pkg::CH_LBRACE) begin
        slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_LBRACE, c, 1'b1, 1'b1, 1'b0);
        n = n + 2'd1;
      end else if (c == jtl_pkg::CH_RBRACE) begin
        slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_RBRACE, c, 1'b1, 1'b1, 1'b0);
        n = n + 2'd1;
      end else if (c == jtl_pkg::CH_COLON) begin
        slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_COLON, c, 1'b1, 1'b1, 1'b0);
        n = n + 2'd1;
      end else if (c == jtl_pkg::CH_COMMA) begin
        slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_COMMA, c, 1'b1, 1'b1, 1'b0);
        n = n + 2'd1;
      end else if (c >= jtl_pkg::CH_ZERO && c <= jtl_pkg::CH_NINE) begin
        slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, c, 1'b1, 1'b0, 1'b0);
        n = n + 2'd1;
        mode_nxt = jtl_pkg::MODE_NUMBER;
      end else if (c == jtl_pkg::CH_QUOTE) begin
        mode_nxt = jtl_pkg::MODE_STRING;
      end else if (c == jtl_pkg::CH_LOW_N || c == jtl_pkg::CH_LOW_T ||
                   c == jtl_pkg::CH_LOW_F) begin
        mode_nxt = jtl_pkg::MODE_LITERAL;
        buf_nxt  = {{(BufW-8){1'b0}}, c};
        len_nxt  = 3'd1;
        fail_nxt = 1'b0;
      end else begin
        n = n;
      end
    end

    // End of file: flush any open token and return to reset state
    if (in_last) begin
      unique case (mode_nxt)
        jtl_pkg::MODE_NUMBER: begin
          slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1, 1'b0);
          n = n + 2'd1;
        end
        jtl_pkg::MODE_STRING: begin
          slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
          n = n + 2'd1;
        end
        jtl_pkg::MODE_LITERAL: begin
          slots[n] = jtl_pkg::mk_res(jtl_pkg::KIND_BOOL, buf_nxt[7:0], 1'b1, 1'b1, 1'b1);
          n = n + 2'd1;
        end
        jtl_pkg::MODE_IDLE: begin
          n = n;
        end
        default: begin
          n = n;
        end
      endcase
      mode_nxt = jtl_pkg::MODE_IDLE;
      buf_nxt  = '0;
      len_nxt  = '0;
      fail_nxt = 1'b0;
    end

    push_entry.cnt = n;
    push_entry.res = slots;
    push           = accept && (n != 2'd0);
  end

endmodule

### hdl/jtl_queue.sv
// Short FIFO of per-byte result groups between the front and back ends.
module jtl_queue #(
  parameter int DEPTH = jtl_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jtl_pkg::entry_t  push_entry,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output jtl_pkg::entry_t  head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jtl_pkg::entry_t slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

### hdl/jtl_back.sv
// Back end: walks queued groups, driving one result beat per cycle while out_ready.
module jtl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  jtl_pkg::entry_t   head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output jtl_pkg::result_t  out_res,
  output logic              out_run_last
);

  logic             out_valid_r;
  jtl_pkg::result_t out_res_r;
  logic             out_last_r;
  logic [1:0]       idx_r;
  logic             adv, take, last_slot;

  assign adv       = !out_valid_r || out_ready;
  assign take      = adv && !q_empty;
  assign last_slot = (idx_r == head.cnt - 2'd1);
  assign pop       = take && last_slot;

  // Control: output valid and slot index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= !q_empty;
      end
      if (take) begin
        idx_r <= last_slot ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  // Payload: load the next slot into the output register
  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r  <= head.res[idx_r];
      out_last_r <= last_slot;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_res      = out_res_r;
  assign out_run_last = out_last_r;

endmodule
